// ===== rtl/qsv_pkg.sv =====
// ============================================================================
// qsv_pkg: shared types and constants of the state vector engine
// Widths, action and gate codes, command and status structs, and the
// fixed-point helper functions used by the datapath and CORDIC.
// ============================================================================
`default_nettype none

package qsv_pkg;

  localparam int MAX_QUBITS   = 10;
  localparam int ADDR_W       = MAX_QUBITS;
  localparam int DEPTH        = 1 << ADDR_W;
  localparam int PAIR_W       = ADDR_W - 1;
  localparam int AMP_W        = 16;
  localparam int FRAC_BITS    = AMP_W - 2;
  localparam int COEF_W       = AMP_W;
  localparam int PROD_W       = 2 * AMP_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int QB_W         = 4;
  localparam int NQ_W         = 5;
  localparam int ANG_W        = 16;
  localparam int PHASE_W      = 32;
  localparam int RIDX_W       = 10;
  localparam int CW           = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;

  localparam longint CORDIC_GAIN_Q30 = 652032874;
  localparam longint INV_SQRT2_Q30   = 759250125;
  localparam longint ONE_VAL         = longint'(1) << FRAC_BITS;
  localparam longint K_VAL           =
      (INV_SQRT2_Q30 + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  localparam logic signed [COEF_W-1:0] ONE_C = COEF_W'(ONE_VAL);
  localparam logic signed [COEF_W-1:0] K_C   = COEF_W'(K_VAL);
  localparam logic [ANG_W-1:0] QUARTER_TURN  = ANG_W'(16384);

  typedef enum logic [4:0] {
    ACT_RESET = 5'd0,  ACT_READ = 5'd1,  ACT_I    = 5'd2,  ACT_H    = 5'd3,
    ACT_X     = 5'd4,  ACT_Y    = 5'd5,  ACT_Z    = 5'd6,  ACT_S    = 5'd7,
    ACT_SDG   = 5'd8,  ACT_T    = 5'd9,  ACT_TDG  = 5'd10, ACT_RX   = 5'd11,
    ACT_RY    = 5'd12, ACT_RZ   = 5'd13, ACT_PH   = 5'd14, ACT_U1   = 5'd15,
    ACT_U2    = 5'd16, ACT_U3   = 5'd17, ACT_CX   = 5'd18, ACT_CY   = 5'd19,
    ACT_CZ    = 5'd20, ACT_SWAP = 5'd21, ACT_CCX  = 5'd22, ACT_C3Z  = 5'd23,
    ACT_C4X   = 5'd24
  } action_e;

  typedef enum logic [3:0] {
    K_H, K_X, K_Y, K_Z, K_S, K_SDG, K_T, K_TDG, K_RX, K_RY, K_RZ, K_PH
  } kind_e;

  typedef enum logic [3:0] {
    S_INIT, S_BOOT, S_IDLE, S_CHECK, S_CLEAR, S_READ, S_PREP, S_CORDIC,
    S_RUN, S_PASS, S_FINISH
  } state_e;

  typedef struct packed {
    logic               clear_start;
    logic               read_start;
    logic [ADDR_W-1:0]  read_addr;
    logic               cordic_start;
    logic [PHASE_W-1:0] phase;
    logic               pass_start;
    logic [QB_W-1:0]    target;
    logic [ADDR_W-1:0]  xmask;
    logic [ADDR_W-1:0]  cmask;
    kind_e              kind;
  } cmd_t;

  typedef struct packed {
    logic               clear_done;
    logic               read_done;
    logic [2*AMP_W-1:0] read_data;
    logic               cordic_done;
    logic               pass_done;
  } sts_t;

  // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32.
  function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = CW'(536870912);
      5'd1:  r = CW'(316933406);
      5'd2:  r = CW'(167458907);
      5'd3:  r = CW'(85004756);
      5'd4:  r = CW'(42667331);
      5'd5:  r = CW'(21354465);
      5'd6:  r = CW'(10679838);
      5'd7:  r = CW'(5340245);
      5'd8:  r = CW'(2670163);
      5'd9:  r = CW'(1335087);
      5'd10: r = CW'(667544);
      5'd11: r = CW'(333772);
      5'd12: r = CW'(166886);
      5'd13: r = CW'(83443);
      5'd14: r = CW'(41722);
      5'd15: r = CW'(20861);
      5'd16: r = CW'(10430);
      5'd17: r = CW'(5215);
      5'd18: r = CW'(2608);
      5'd19: r = CW'(1304);
      5'd20: r = CW'(652);
      5'd21: r = CW'(326);
      5'd22: r = CW'(163);
      5'd23: r = CW'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rounds a Q4.30 value to a coefficient and clamps it to plus or minus one.
  function automatic logic signed [COEF_W-1:0] to_coef(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] one;
    one = CW'(ONE_VAL);
    r   = (v + CW'(longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (r > one) begin
      r = one;
    end else if (r < -one) begin
      r = -one;
    end
    return COEF_W'(r);
  endfunction

  // Rounds half up, drops the fraction and saturates to the amplitude width.
  function automatic logic signed [AMP_W-1:0] finish_amp(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((longint'(1) << (AMP_W - 1)) - 1);
    lo = -hi - ACC_W'(1);
    r  = (acc + ACC_W'(longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return AMP_W'(r);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qsv_cordic.sv =====
// ============================================================================
// qsv_cordic: iterative cosine and sine of a phase
// One rotation step per cycle over 24 steps, then quadrant fix-up and
// rounding to coefficient format. Results hold until the next computation ends.
// ============================================================================
`default_nettype none

module qsv_cordic import qsv_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [PHASE_W-1:0]       phase_i,
  output      logic                     done_o,
  output      logic signed [COEF_W-1:0] cos_o,
  output      logic signed [COEF_W-1:0] sin_o
);

  logic                     busy_q, fin_q, done_q;
  logic [STEP_W-1:0]        it_q;
  logic [1:0]               quad_q;
  logic signed [CW-1:0]     x_q, y_q, z_q;
  logic signed [COEF_W-1:0] c_q, s_q;

  logic [PHASE_W-1:0]   rounded;
  logic [1:0]           quad;
  logic [PHASE_W-1:0]   rem;
  logic signed [CW-1:0] dx, dy, at;
  logic signed [CW-1:0] cx, sy;

  assign rounded = phase_i + PHASE_W'(32'h2000_0000);
  assign quad    = rounded[PHASE_W-1:PHASE_W-2];
  assign rem     = phase_i - {quad, {(PHASE_W-2){1'b0}}};
  assign dx      = y_q >>> it_q;
  assign dy      = x_q >>> it_q;
  assign at      = atan_turn(it_q);

  always_comb begin
    case (quad_q)
      2'd0: begin
        cx = x_q;
        sy = y_q;
      end
      2'd1: begin
        cx = -y_q;
        sy = x_q;
      end
      2'd2: begin
        cx = -x_q;
        sy = -y_q;
      end
      default: begin
        cx = y_q;
        sy = -x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        if (it_q == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          it_q <= it_q + STEP_W'(1);
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= quad;
      x_q    <= CW'(CORDIC_GAIN_Q30);
      y_q    <= '0;
      z_q    <= {{(CW-PHASE_W){rem[PHASE_W-1]}}, rem};
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
    if (fin_q) begin
      c_q <= to_coef(cx);
      s_q <= to_coef(sy);
    end
  end

  assign done_o = done_q;
  assign cos_o  = c_q;
  assign sin_o  = s_q;

endmodule

`default_nettype wire

// ===== rtl/qsv_datapath.sv =====
// ============================================================================
// qsv_datapath: amplitude store and pair-update pipeline
// Holds the amplitude memory, the clearing sweep, single reads, and the pair
// pipeline (read, multiply, round, two writes), in which pairs overlap.
// ============================================================================
`default_nettype none

module qsv_datapath import qsv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  output      sts_t sts_o
);

  // Amplitude memory: real part in the upper half of each word.
  logic [2*AMP_W-1:0] mem [DEPTH];
  logic               we;
  logic [ADDR_W-1:0]  wa, ra, rb;
  logic [2*AMP_W-1:0] wd, rda_q, rdb_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_q <= mem[ra];
    rdb_q <= mem[rb];
  end

  // Clearing sweep.
  logic              clr_act_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b0;
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_start) begin
      clr_act_q <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_act_q) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      if (&clr_cnt_q) begin
        clr_act_q <= 1'b0;
      end
    end
  end

  // Single read.
  logic rd_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.read_start;
    end
  end

  // Angle unit.
  logic                     cor_done;
  logic signed [COEF_W-1:0] cor_c, cor_s;

  qsv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .phase_i (cmd_i.phase),
    .done_o  (cor_done),
    .cos_o   (cor_c),
    .sin_o   (cor_s)
  );

  // Matrix coefficients: re0, im0, re1, im1, re2, im2, re3, im3.
  logic signed [COEF_W-1:0] cf_d [8];
  logic signed [COEF_W-1:0] cf_q [8];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      cf_d[n] = '0;
    end
    case (cmd_i.kind)
      K_H: begin
        cf_d[0] = K_C;
        cf_d[2] = K_C;
        cf_d[4] = K_C;
        cf_d[6] = -K_C;
      end
      K_X: begin
        cf_d[2] = ONE_C;
        cf_d[4] = ONE_C;
      end
      K_Y: begin
        cf_d[3] = -ONE_C;
        cf_d[5] = ONE_C;
      end
      K_Z: begin
        cf_d[0] = ONE_C;
        cf_d[6] = -ONE_C;
      end
      K_S: begin
        cf_d[0] = ONE_C;
        cf_d[7] = ONE_C;
      end
      K_SDG: begin
        cf_d[0] = ONE_C;
        cf_d[7] = -ONE_C;
      end
      K_T: begin
        cf_d[0] = ONE_C;
        cf_d[6] = K_C;
        cf_d[7] = K_C;
      end
      K_TDG: begin
        cf_d[0] = ONE_C;
        cf_d[6] = K_C;
        cf_d[7] = -K_C;
      end
      K_RX: begin
        cf_d[0] = cor_c;
        cf_d[3] = -cor_s;
        cf_d[5] = -cor_s;
        cf_d[6] = cor_c;
      end
      K_RY: begin
        cf_d[0] = cor_c;
        cf_d[2] = -cor_s;
        cf_d[4] = cor_s;
        cf_d[6] = cor_c;
      end
      K_RZ: begin
        cf_d[0] = cor_c;
        cf_d[1] = -cor_s;
        cf_d[6] = cor_c;
        cf_d[7] = cor_s;
      end
      K_PH: begin
        cf_d[0] = ONE_C;
        cf_d[6] = cor_c;
        cf_d[7] = cor_s;
      end
      default: begin
        cf_d[0] = ONE_C;
        cf_d[6] = ONE_C;
      end
    endcase
  end

  // Pair sequencer: issues each pair of a pass in turn, paced by a toggle.
  logic              pa_act_q, tog_q;
  logic [PAIR_W-1:0] p_q;
  logic [QB_W-1:0]   tgt_q;
  logic [ADDR_W-1:0] xmask_q, cmask_q;

  logic              issue;
  logic [ADDR_W-1:0] tbit, lowm, pe, base, partner;
  logic              qual;

  assign issue   = pa_act_q && !tog_q;
  assign tbit    = ADDR_W'(1) << tgt_q;
  assign lowm    = tbit - ADDR_W'(1);
  assign pe      = ADDR_W'(p_q);
  assign base    = (pe & lowm) | ((pe & ~lowm) << 1);
  assign partner = base ^ tbit ^ xmask_q;
  assign qual    = (base & cmask_q) == cmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_act_q <= 1'b0;
      tog_q    <= 1'b0;
      p_q      <= '0;
    end else if (cmd_i.pass_start) begin
      pa_act_q <= 1'b1;
      tog_q    <= 1'b0;
      p_q      <= '0;
    end else if (pa_act_q) begin
      tog_q <= !tog_q;
      if (issue) begin
        p_q <= p_q + PAIR_W'(1);
        if (&p_q) begin
          pa_act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_start) begin
      tgt_q   <= cmd_i.target;
      xmask_q <= cmd_i.xmask;
      cmask_q <= cmd_i.cmask;
      for (int n = 0; n < 8; n++) begin
        cf_q[n] <= cf_d[n];
      end
    end
  end

  assign ra = issue ? base : cmd_i.read_addr;
  assign rb = partner;

  // Pipeline stages.
  logic                     v1_q, v2_q, v3_q, wp_q;
  logic                     l1_q, l2_q, l3_q;
  logic                     q1_q, q2_q, q3_q;
  logic [ADDR_W-1:0]        a1_q, a2_q, a3_q, b1_q, b2_q, b3_q;
  logic signed [PROD_W-1:0] pp_q [16];
  logic [2*AMP_W-1:0]       wi_q, wj_q;

  logic signed [AMP_W-1:0] ar, ai, br, bi;
  logic signed [ACC_W-1:0] s_ir, s_ii, s_jr, s_ji;

  assign ar = rda_q[2*AMP_W-1:AMP_W];
  assign ai = rda_q[AMP_W-1:0];
  assign br = rdb_q[2*AMP_W-1:AMP_W];
  assign bi = rdb_q[AMP_W-1:0];

  assign s_ir = ACC_W'(pp_q[0])  - ACC_W'(pp_q[1])  + ACC_W'(pp_q[2])  - ACC_W'(pp_q[3]);
  assign s_ii = ACC_W'(pp_q[4])  + ACC_W'(pp_q[5])  + ACC_W'(pp_q[6])  + ACC_W'(pp_q[7]);
  assign s_jr = ACC_W'(pp_q[8])  - ACC_W'(pp_q[9])  + ACC_W'(pp_q[10]) - ACC_W'(pp_q[11]);
  assign s_ji = ACC_W'(pp_q[12]) + ACC_W'(pp_q[13]) + ACC_W'(pp_q[14]) + ACC_W'(pp_q[15]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      wp_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      wp_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a1_q <= base;
      b1_q <= partner;
      q1_q <= qual;
      l1_q <= &p_q;
    end
    if (v1_q) begin
      a2_q <= a1_q;
      b2_q <= b1_q;
      q2_q <= q1_q;
      l2_q <= l1_q;
      pp_q[0]  <= cf_q[0] * ar;
      pp_q[1]  <= cf_q[1] * ai;
      pp_q[2]  <= cf_q[2] * br;
      pp_q[3]  <= cf_q[3] * bi;
      pp_q[4]  <= cf_q[0] * ai;
      pp_q[5]  <= cf_q[1] * ar;
      pp_q[6]  <= cf_q[2] * bi;
      pp_q[7]  <= cf_q[3] * br;
      pp_q[8]  <= cf_q[4] * ar;
      pp_q[9]  <= cf_q[5] * ai;
      pp_q[10] <= cf_q[6] * br;
      pp_q[11] <= cf_q[7] * bi;
      pp_q[12] <= cf_q[4] * ai;
      pp_q[13] <= cf_q[5] * ar;
      pp_q[14] <= cf_q[6] * bi;
      pp_q[15] <= cf_q[7] * br;
    end
    if (v2_q) begin
      a3_q <= a2_q;
      b3_q <= b2_q;
      q3_q <= q2_q;
      l3_q <= l2_q;
      wi_q <= {finish_amp(s_ir), finish_amp(s_ii)};
      wj_q <= {finish_amp(s_jr), finish_amp(s_ji)};
    end
  end

  // Write port: sweep, then the first and second word of each pair.
  always_comb begin
    we = 1'b0;
    wa = a3_q;
    wd = wi_q;
    if (clr_act_q) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd = (clr_cnt_q == '0) ? {ONE_C, {AMP_W{1'b0}}} : '0;
    end else if (v3_q && q3_q) begin
      we = 1'b1;
    end else if (wp_q && q3_q) begin
      we = 1'b1;
      wa = b3_q;
      wd = wj_q;
    end
  end

  assign sts_o.clear_done  = clr_act_q && (&clr_cnt_q);
  assign sts_o.read_done   = rd_pend_q;
  assign sts_o.read_data   = rda_q;
  assign sts_o.cordic_done = cor_done;
  assign sts_o.pass_done   = wp_q && l3_q;

endmodule

`default_nettype wire

// ===== rtl/qsv_ctrl.sv =====
// ============================================================================
// qsv_ctrl: transaction controller
// Takes input transactions, checks qubit indexes, sequences clear, read,
// angle and gate passes on the datapath, and holds the result register.
// ============================================================================
`default_nettype none

module qsv_ctrl import qsv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [4:0]         action_i,
  input  wire logic [QB_W-1:0]    target_i,
  input  wire logic [QB_W-1:0]    control_a_i,
  input  wire logic [QB_W-1:0]    control_b_i,
  input  wire logic [QB_W-1:0]    control_c_i,
  input  wire logic [QB_W-1:0]    control_d_i,
  input  wire logic [ANG_W-1:0]   angle_theta_i,
  input  wire logic [ANG_W-1:0]   angle_phi_i,
  input  wire logic [ANG_W-1:0]   angle_lambda_i,
  input  wire logic [RIDX_W-1:0]  read_index_i,
  input  wire logic               cfg_we_i,
  input  wire logic [NQ_W-1:0]    cfg_wdata_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               status_o,
  output      logic signed [15:0] amp_real_o,
  output      logic signed [15:0] amp_imag_o,
  output      cmd_t               cmd_o,
  input  wire sts_t               sts_i
);

  state_e state_q, state_d;

  action_e           act_q;
  logic [QB_W-1:0]   tgt_q, ca_q, cb_q, cc_q, cd_q;
  logic [ANG_W-1:0]  th_q, ph_q, la_q;
  logic [RIDX_W-1:0] ridx_q;
  logic [NQ_W-1:0]   qiu_q;
  logic [1:0]        pidx_q;
  logic              res_status_q;
  logic [15:0]       res_re_q, res_im_q;
  logic              out_valid_q, out_status_q;
  logic [15:0]       out_re_q, out_im_q;

  // Index check: every named qubit below the bound and all of them distinct.
  logic [QB_W-1:0] qs [5];
  logic [2:0]      count;
  logic [NQ_W-1:0] nq;
  logic            err;

  assign qs[0] = tgt_q;
  assign qs[1] = ca_q;
  assign qs[2] = cb_q;
  assign qs[3] = cc_q;
  assign qs[4] = cd_q;
  assign nq    = (qiu_q < NQ_W'(MAX_QUBITS)) ? qiu_q : NQ_W'(MAX_QUBITS);

  always_comb begin
    case (act_q)
      ACT_CX, ACT_CY, ACT_CZ, ACT_SWAP: count = 3'd2;
      ACT_CCX: count = 3'd3;
      ACT_C3Z: count = 3'd4;
      ACT_C4X: count = 3'd5;
      default: count = 3'd1;
    endcase
    err = 1'b0;
    for (int a = 0; a < 5; a++) begin
      if (3'(a) < count) begin
        if (NQ_W'(qs[a]) >= nq) begin
          err = 1'b1;
        end
        for (int b = 0; b < a; b++) begin
          if (qs[a] == qs[b]) begin
            err = 1'b1;
          end
        end
      end
    end
  end

  // Pass plan for the current pass of the current gate.
  logic               is_u, use_cor, last_pass;
  kind_e              kind;
  logic [PHASE_W-1:0] phase;
  logic [ADDR_W-1:0]  cmask, xmask, bit_a, bit_b, bit_c, bit_d;

  assign bit_a = ADDR_W'(1) << ca_q;
  assign bit_b = ADDR_W'(1) << cb_q;
  assign bit_c = ADDR_W'(1) << cc_q;
  assign bit_d = ADDR_W'(1) << cd_q;
  assign is_u  = (act_q == ACT_U1) || (act_q == ACT_U2) || (act_q == ACT_U3);
  assign last_pass = !is_u || (pidx_q == 2'd2);

  always_comb begin
    kind    = K_X;
    use_cor = 1'b0;
    phase   = {1'b0, th_q, 15'b0};
    cmask   = '0;
    xmask   = '0;
    case (act_q)
      ACT_H:   kind = K_H;
      ACT_X:   kind = K_X;
      ACT_Y:   kind = K_Y;
      ACT_Z:   kind = K_Z;
      ACT_S:   kind = K_S;
      ACT_SDG: kind = K_SDG;
      ACT_T:   kind = K_T;
      ACT_TDG: kind = K_TDG;
      ACT_RX: begin
        kind    = K_RX;
        use_cor = 1'b1;
      end
      ACT_RY: begin
        kind    = K_RY;
        use_cor = 1'b1;
      end
      ACT_RZ: begin
        kind    = K_RZ;
        use_cor = 1'b1;
      end
      ACT_PH: begin
        kind    = K_PH;
        use_cor = 1'b1;
        phase   = {th_q, 16'b0};
      end
      ACT_U1, ACT_U2, ACT_U3: begin
        use_cor = 1'b1;
        case (pidx_q)
          2'd0: begin
            kind  = K_RZ;
            phase = {1'b0, la_q, 15'b0};
          end
          2'd1: begin
            kind = K_RY;
            case (act_q)
              ACT_U1:  phase = '0;
              ACT_U2:  phase = {1'b0, QUARTER_TURN, 15'b0};
              default: phase = {1'b0, th_q, 15'b0};
            endcase
          end
          default: begin
            kind  = K_RZ;
            phase = (act_q == ACT_U1) ? '0 : {1'b0, ph_q, 15'b0};
          end
        endcase
      end
      ACT_CX: begin
        kind  = K_X;
        cmask = bit_a;
      end
      ACT_CY: begin
        kind  = K_Y;
        cmask = bit_a;
      end
      ACT_CZ: begin
        kind  = K_Z;
        cmask = bit_a;
      end
      // Swap exchanges the word with target clear and other set against
      // the word with target set and other clear.
      ACT_SWAP: begin
        kind  = K_X;
        cmask = bit_a;
        xmask = bit_a;
      end
      ACT_CCX: begin
        kind  = K_X;
        cmask = bit_a | bit_b;
      end
      ACT_C3Z: begin
        kind  = K_Z;
        cmask = bit_a | bit_b | bit_c;
      end
      ACT_C4X: begin
        kind  = K_X;
        cmask = bit_a | bit_b | bit_c | bit_d;
      end
      default: kind = K_X;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: state_d = S_BOOT;
      S_BOOT: begin
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        case (act_q)
          ACT_RESET: state_d = S_CLEAR;
          ACT_READ:  state_d = S_READ;
          ACT_I:     state_d = S_FINISH;
          ACT_H, ACT_X, ACT_Y, ACT_Z, ACT_S, ACT_SDG, ACT_T, ACT_TDG, ACT_RX,
          ACT_RY, ACT_RZ, ACT_PH, ACT_U1, ACT_U2, ACT_U3, ACT_CX, ACT_CY,
          ACT_CZ, ACT_SWAP, ACT_CCX, ACT_C3Z, ACT_C4X: begin
            state_d = err ? S_FINISH : S_PREP;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        if (sts_i.read_done) begin
          state_d = S_FINISH;
        end
      end
      S_PREP: state_d = use_cor ? S_CORDIC : S_RUN;
      S_CORDIC: begin
        if (sts_i.cordic_done) begin
          state_d = S_RUN;
        end
      end
      S_RUN: state_d = S_PASS;
      S_PASS: begin
        if (sts_i.pass_done) begin
          state_d = last_pass ? S_FINISH : S_PREP;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o         = (state_q == S_IDLE);
    cmd_o.clear_start  = (state_q == S_INIT) ||
                         ((state_q == S_CHECK) && (act_q == ACT_RESET));
    cmd_o.read_start   = (state_q == S_CHECK) && (act_q == ACT_READ);
    cmd_o.read_addr    = ADDR_W'(ridx_q);
    cmd_o.cordic_start = (state_q == S_PREP) && use_cor;
    cmd_o.phase        = phase;
    cmd_o.pass_start   = (state_q == S_RUN);
    cmd_o.target       = tgt_q;
    cmd_o.xmask        = xmask;
    cmd_o.cmask        = cmask;
    cmd_o.kind         = kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      qiu_q       <= NQ_W'(10);
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        qiu_q <= cfg_wdata_i;
      end
      if (state_q == S_CHECK) begin
        pidx_q <= '0;
      end else if ((state_q == S_PASS) && sts_i.pass_done && !last_pass) begin
        pidx_q <= pidx_q + 2'd1;
      end
      if ((state_q == S_FINISH) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_e'(action_i);
      tgt_q  <= target_i;
      ca_q   <= control_a_i;
      cb_q   <= control_b_i;
      cc_q   <= control_c_i;
      cd_q   <= control_d_i;
      th_q   <= angle_theta_i;
      ph_q   <= angle_phi_i;
      la_q   <= angle_lambda_i;
      ridx_q <= read_index_i;
    end
    if (state_q == S_CHECK) begin
      res_re_q <= '0;
      res_im_q <= '0;
      case (act_q)
        ACT_RESET, ACT_READ: res_status_q <= 1'b0;
        ACT_I, ACT_H, ACT_X, ACT_Y, ACT_Z, ACT_S, ACT_SDG, ACT_T, ACT_TDG,
        ACT_RX, ACT_RY, ACT_RZ, ACT_PH, ACT_U1, ACT_U2, ACT_U3, ACT_CX, ACT_CY,
        ACT_CZ, ACT_SWAP, ACT_CCX, ACT_C3Z, ACT_C4X: res_status_q <= err;
        default: res_status_q <= 1'b1;
      endcase
    end
    if ((state_q == S_READ) && sts_i.read_done) begin
      res_re_q <= sts_i.read_data[2*AMP_W-1:AMP_W];
      res_im_q <= sts_i.read_data[AMP_W-1:0];
    end
    if ((state_q == S_FINISH) && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_re_q     <= res_re_q;
      out_im_q     <= res_im_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign amp_real_o  = out_re_q;
  assign amp_imag_o  = out_im_q;

endmodule

`default_nettype wire

// ===== rtl/quantum_gate_state_vector_engine.sv =====
// ============================================================================
// quantum_gate_state_vector_engine: state vector gate engine
// Keeps 1024 complex Q2.14 amplitudes and applies gates, reads and resets
// to them, one transaction at a time, with one result per transaction.
// ============================================================================
// Each input transaction is one action: a store reset, a read of one
// amplitude, or a gate on the whole store. A gate runs as passes over all
// 512 amplitude pairs; the amplitude memory has one write port, so the two
// words of each pair are written one after the other. Rotation gates first
// run the iterative CORDIC, and U1, U2 and U3 run three passes. A store
// reset sweeps the memory once, and the same sweep runs after the reset pin
// is released, while no input transaction is accepted. A rejected gate (bad
// or repeated qubit index, unknown action) answers status 1 with the store
// untouched. The result sits in an output register, so the next transaction
// may be accepted while a result waits. The qubit bound register may be
// written whenever the engine is idle.
`default_nettype none

module quantum_gate_state_vector_engine import qsv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [4:0]         action_i,
  input  wire logic [3:0]         target_i,
  input  wire logic [3:0]         control_a_i,
  input  wire logic [3:0]         control_b_i,
  input  wire logic [3:0]         control_c_i,
  input  wire logic [3:0]         control_d_i,
  input  wire logic [15:0]        angle_theta_i,
  input  wire logic [15:0]        angle_phi_i,
  input  wire logic [15:0]        angle_lambda_i,
  input  wire logic [9:0]         read_index_i,
  input  wire logic               cfg_we_i,
  input  wire logic [4:0]         cfg_wdata_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               status_o,
  output      logic signed [15:0] amp_real_o,
  output      logic signed [15:0] amp_imag_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller owns the handshakes and sequencing.
  qsv_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .target_i       (target_i),
    .control_a_i    (control_a_i),
    .control_b_i    (control_b_i),
    .control_c_i    (control_c_i),
    .control_d_i    (control_d_i),
    .angle_theta_i  (angle_theta_i),
    .angle_phi_i    (angle_phi_i),
    .angle_lambda_i (angle_lambda_i),
    .read_index_i   (read_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .amp_real_o     (amp_real_o),
    .amp_imag_o     (amp_imag_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  // The datapath holds the memory, the pair pipeline and the CORDIC.
  qsv_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire
